// ===== src/dsps_pkg.sv =====
// Shared types, constants and arithmetic helpers of the direction-set pattern search.
// Used by the channel interfaces, the search core and the top level.
// Depends on nothing else.
package dsps_pkg;

  localparam int VALUE_W = 32;
  localparam int COORD_W = 4;
  localparam int EVAL_W = 25;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_DIM_DEFAULT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RHO_INITIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO_STOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SUCCESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FAILURE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVALUATIONS = 3'd4;

  localparam logic [30:0] RHO_INITIAL_RST = 31'd65536;
  localparam logic [30:0] RHO_STOP_RST = 31'd66;
  localparam logic [18:0] GAIN_SUCCESS_RST = 19'd131072;
  localparam logic [18:0] GAIN_FAILURE_RST = 19'd32768;
  localparam logic [23:0] MAX_EVALUATIONS_RST = 24'd1000;

  // Input actions and result kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_VALUE = 1'b1;
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic [30:0] rho_initial;
    logic [30:0] rho_stop;
    logic [18:0] gain_success;
    logic [18:0] gain_failure;
    logic [23:0] max_evaluations;
  } cfg_regs_t;

  // a + b or a - b, saturated to the signed 32-bit range.
  function automatic logic signed [VALUE_W-1:0] sat_addsub(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b,
    input logic sub
  );
    logic signed [VALUE_W:0] s;
    s = sub ? (VALUE_W+1)'(a) - (VALUE_W+1)'(b) : (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end
    return s[VALUE_W-1:0];
  endfunction

  // Q16.16 product rounded to nearest, ties away from zero, saturated to 32 bits.
  function automatic logic signed [VALUE_W-1:0] scale_round(input logic signed [51:0] p);
    logic neg;
    logic [51:0] mag;
    logic [51:0] sum;
    logic [35:0] r;
    neg = p[51];
    mag = neg ? 52'(-p) : 52'(p);
    sum = mag + 52'd32768;
    r = sum[51:16];
    if (neg) begin
      if (r >= 36'h080000000) begin
        return 32'sh80000000;
      end
      return 32'(~r[31:0] + 32'd1);
    end
    if (r > 36'h07FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end
    return r[31:0];
  endfunction

endpackage

// ===== src/dsps_item_if.sv =====
// Input channel of the pattern search: action, value and last-coordinate mark.
// Depends on dsps_pkg.
interface dsps_item_if;
  logic valid;
  logic ready;
  logic action;
  logic signed [dsps_pkg::VALUE_W-1:0] value;
  logic last_coord;
  modport source(output valid, action, value, last_coord, input ready);
  modport sink(input valid, action, value, last_coord, output ready);
endinterface

// ===== src/dsps_result_if.sv =====
// Result channel of the pattern search: one point coordinate per transaction.
// Depends on dsps_pkg.
interface dsps_result_if;
  logic valid;
  logic ready;
  logic kind;
  logic [dsps_pkg::COORD_W-1:0] coord_index;
  logic signed [dsps_pkg::VALUE_W-1:0] coord_value;
  logic last;
  logic signed [dsps_pkg::VALUE_W-1:0] best_score;
  modport source(output valid, kind, coord_index, coord_value, last, best_score, input ready);
  modport sink(input valid, kind, coord_index, coord_value, last, best_score, output ready);
endinterface

// ===== src/dsps_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on dsps_pkg.
interface dsps_cfg_if;
  logic valid;
  logic ready;
  logic [dsps_pkg::CFG_IDX_W-1:0] index;
  logic [dsps_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/dsps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dsps_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module dsps_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[DVD_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/dsps_isqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
// No dependencies.
module dsps_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n <= radicand;
        res <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (n >= trial) begin
          n <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/dsps_core.sv =====
// Search sequencer and datapath: point memories, trial updates, length pass,
// stable sort by squared length and mean replacement.
// Depends on dsps_pkg, the item and result interfaces, dsps_ram, dsps_div and dsps_isqrt.
module dsps_core #(
  parameter int MAX_DIM = dsps_pkg::MAX_DIM_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input dsps_pkg::cfg_regs_t   regs,
  dsps_item_if.sink            item,
  dsps_result_if.source        result
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int ROWS = 1 << IW;
  localparam int DIR_AW = 2 * IW + 1;
  localparam int DIR_DEPTH = 1 << DIR_AW;
  localparam int WIDE_W = 32 + CW;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_DIR, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT,
    S_UPD_DEC, S_UPD_RD, S_UPD_MUL, S_UPD_WR,
    S_SQ_RD, S_SQ_MUL, S_SQ_ACC, S_SQ_KEY, S_SQ_ROOT, S_RHO_DIV, S_RHO_WAIT,
    S_SRT_KRD, S_SRT_KLD, S_SRT_SRD, S_SRT_SCMP, S_CPY_RD, S_CPY_WR,
    S_MEAN_RD, S_MEAN_ACC, S_MEAN_DIV, S_MEAN_WAIT, S_MEAN_WR, S_FINISH
  } state_t;

  typedef enum logic [2:0] {PH_LOAD, PH_INIT, PH_MINUS, PH_PLUS, PH_DONE} phase_t;
  typedef enum logic [1:0] {SG_NONE, SG_MINUS, SG_PLUS} sign_t;

  state_t state;
  phase_t phase;
  sign_t  emit_sign;
  sign_t  sel;

  logic [CW-1:0] dim;
  logic [CW-1:0] dim_m1;
  logic [IW-1:0] k;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [CW-1:0] scan;
  logic [IW-1:0] rank;
  logic          bank;
  logic          success;
  logic          stop;
  logic          emit_kind;
  logic [dsps_pkg::EVAL_W-1:0] eval_count;

  logic signed [31:0] best;
  logic signed [31:0] first;
  logic signed [31:0] f2;
  logic signed [31:0] mean;
  logic signed [51:0] prod;
  logic signed [63:0] sq;
  logic [63:0]        acc;
  logic [64:0]        acc_sum;
  logic [63:0]        ki;
  logic [WIDE_W-1:0]  total;
  logic signed [WIDE_W-1:0] msum;
  logic [WIDE_W-1:0]  msum_mag;

  logic        o_valid;
  logic        o_kind;
  logic [dsps_pkg::COORD_W-1:0] o_idx;
  logic signed [31:0] o_val;
  logic        o_last;
  logic signed [31:0] o_best;

  // Memory ports.
  logic               g_we;
  logic [IW-1:0]      g_waddr;
  logic signed [31:0] g_wdata;
  logic [IW-1:0]      g_raddr;
  logic signed [31:0] g_rdata;
  logic               d_we;
  logic               d_wbank;
  logic [IW-1:0]      d_wrow;
  logic [IW-1:0]      d_rrow;
  logic signed [31:0] d_wdata;
  logic signed [31:0] d_rdata;
  logic               k_we;
  logic [IW-1:0]      k_raddr;
  logic [63:0]        k_rdata;

  logic              sq_start;
  logic              sq_done;
  logic [31:0]       sq_root;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [WIDE_W-1:0] div_dividend;
  logic [WIDE_W-1:0] div_quotient;

  logic               accept;
  logic signed [31:0] upd_guess;
  logic signed [31:0] emit_val;
  logic [18:0]        gain_sel;
  logic               best1_lt;
  logic signed [31:0] best1;

  dsps_ram #(.WIDTH(32), .DEPTH(ROWS)) u_guess (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  dsps_ram #(.WIDTH(32), .DEPTH(DIR_DEPTH)) u_dirs (
    .clk(clk), .we(d_we), .waddr({d_wbank, d_wrow, col[IW-1:0]}), .wdata(d_wdata),
    .raddr({bank, d_rrow, col[IW-1:0]}), .rdata(d_rdata)
  );

  dsps_ram #(.WIDTH(64), .DEPTH(ROWS)) u_keys (
    .clk(clk), .we(k_we), .waddr(row[IW-1:0]), .wdata(acc),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  dsps_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc),
    .done(sq_done), .root(sq_root)
  );

  dsps_div #(.DVD_W(WIDE_W), .DVS_W(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend), .divisor(dim),
    .busy(div_busy), .done(div_done), .quotient(div_quotient)
  );

  assign item.ready = (state == S_IDLE);
  assign accept = item.valid && item.ready;

  assign result.valid = o_valid;
  assign result.kind = o_kind;
  assign result.coord_index = o_idx;
  assign result.coord_value = o_val;
  assign result.last = o_last;
  assign result.best_score = o_best;

  assign dim_m1 = dim - 1'b1;
  assign upd_guess = dsps_pkg::sat_addsub(g_rdata, d_rdata, sel == SG_MINUS);
  assign emit_val = (emit_sign == SG_NONE) ? g_rdata :
                    dsps_pkg::sat_addsub(g_rdata, d_rdata, emit_sign == SG_MINUS);
  assign gain_sel = success ? regs.gain_success : regs.gain_failure;
  assign acc_sum = {1'b0, acc} + {1'b0, sq};
  assign msum_mag = msum[WIDE_W-1] ? WIDE_W'(-msum) : WIDE_W'(msum);
  assign best1_lt = first < best;
  assign best1 = best1_lt ? first : best;

  always_comb begin
    g_we = 1'b0;
    g_waddr = col[IW-1:0];
    g_wdata = upd_guess;
    g_raddr = col[IW-1:0];
    d_we = 1'b0;
    d_wbank = bank;
    d_wrow = row[IW-1:0];
    d_rrow = row[IW-1:0];
    d_wdata = '0;
    k_we = 1'b0;
    k_raddr = row[IW-1:0];
    sq_start = 1'b0;
    div_start = 1'b0;
    div_dividend = total;
    unique case (state) inside
      S_IDLE: begin
        if (accept && phase == PH_LOAD && item.action == dsps_pkg::ACT_LOAD &&
            dim < CW'(MAX_DIM)) begin
          g_we = 1'b1;
          g_waddr = dim[IW-1:0];
          g_wdata = item.value;
        end
      end
      S_INIT_DIR: begin
        d_we = 1'b1;
        d_wdata = (row == col) ? {1'b0, regs.rho_initial} : '0;
      end
      S_EMIT_RD, S_UPD_RD: begin
        d_rrow = k;
      end
      S_UPD_MUL: begin
        g_we = (sel != SG_NONE);
      end
      S_UPD_WR: begin
        d_we = 1'b1;
        d_wrow = k;
        d_wdata = dsps_pkg::scale_round(prod);
      end
      S_SQ_KEY: begin
        k_we = 1'b1;
        sq_start = 1'b1;
      end
      S_RHO_DIV: begin
        div_start = 1'b1;
      end
      S_SRT_SRD: begin
        k_raddr = scan[IW-1:0];
      end
      S_CPY_WR: begin
        d_we = 1'b1;
        d_wbank = ~bank;
        d_wrow = rank;
        d_wdata = d_rdata;
      end
      S_MEAN_DIV: begin
        div_start = 1'b1;
        div_dividend = msum_mag;
      end
      S_MEAN_WR: begin
        d_we = 1'b1;
        d_wrow = dim_m1[IW-1:0];
        d_wdata = mean;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LOAD;
      dim <= '0;
      k <= '0;
      bank <= 1'b0;
      best <= '0;
      first <= '0;
      eval_count <= '0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase == PH_LOAD) begin
              if (item.action == dsps_pkg::ACT_LOAD) begin
                if (dim < CW'(MAX_DIM)) begin
                  dim <= dim + 1'b1;
                end
                if (item.last_coord) begin
                  row <= '0;
                  col <= '0;
                  state <= S_INIT_DIR;
                end
              end
            end else if (item.action == dsps_pkg::ACT_VALUE && phase != PH_DONE) begin
              if (eval_count != '1) begin
                eval_count <= eval_count + 1'b1;
              end
              col <= '0;
              unique case (phase)
                PH_INIT: begin
                  best <= item.value;
                  phase <= PH_MINUS;
                  emit_kind <= dsps_pkg::KIND_POINT;
                  emit_sign <= SG_MINUS;
                  state <= S_EMIT_RD;
                end
                PH_MINUS: begin
                  first <= item.value;
                  phase <= PH_PLUS;
                  emit_kind <= dsps_pkg::KIND_POINT;
                  emit_sign <= SG_PLUS;
                  state <= S_EMIT_RD;
                end
                default: begin
                  f2 <= item.value;
                  state <= S_UPD_DEC;
                end
              endcase
            end
          end
        end
        S_INIT_DIR: begin
          if (col == dim_m1) begin
            col <= '0;
            if (row == dim_m1) begin
              phase <= PH_INIT;
              k <= '0;
              emit_kind <= dsps_pkg::KIND_POINT;
              emit_sign <= SG_NONE;
              state <= S_EMIT_RD;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          o_valid <= 1'b1;
          o_kind <= emit_kind;
          o_idx <= dsps_pkg::COORD_W'(col);
          o_val <= emit_val;
          o_last <= (col == dim_m1);
          o_best <= best;
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (result.ready) begin
            o_valid <= 1'b0;
            if (col == dim_m1) begin
              state <= S_IDLE;
            end else begin
              col <= col + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        S_UPD_DEC: begin
          // The second trial is judged against the best value after the first.
          if (f2 < best1) begin
            best <= f2;
            sel <= SG_PLUS;
          end else begin
            best <= best1;
            sel <= best1_lt ? SG_MINUS : SG_NONE;
          end
          success <= best1_lt || (f2 < best1);
          col <= '0;
          state <= S_UPD_RD;
        end
        S_UPD_RD: state <= S_UPD_MUL;
        S_UPD_MUL: begin
          prod <= d_rdata * $signed({1'b0, gain_sel});
          state <= S_UPD_WR;
        end
        S_UPD_WR: begin
          if (col == dim_m1) begin
            row <= '0;
            col <= '0;
            acc <= '0;
            total <= '0;
            state <= S_SQ_RD;
          end else begin
            col <= col + 1'b1;
            state <= S_UPD_RD;
          end
        end
        S_SQ_RD: state <= S_SQ_MUL;
        S_SQ_MUL: begin
          sq <= d_rdata * d_rdata;
          state <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          acc <= acc_sum[64] ? '1 : acc_sum[63:0];
          if (col == dim_m1) begin
            state <= S_SQ_KEY;
          end else begin
            col <= col + 1'b1;
            state <= S_SQ_RD;
          end
        end
        S_SQ_KEY: state <= S_SQ_ROOT;
        S_SQ_ROOT: begin
          if (sq_done) begin
            total <= total + WIDE_W'(sq_root);
            acc <= '0;
            col <= '0;
            if (row == dim_m1) begin
              state <= S_RHO_DIV;
            end else begin
              row <= row + 1'b1;
              state <= S_SQ_RD;
            end
          end
        end
        S_RHO_DIV: state <= S_RHO_WAIT;
        S_RHO_WAIT: begin
          if (div_done) begin
            stop <= (div_quotient < WIDE_W'(regs.rho_stop)) ||
                    (eval_count > {1'b0, regs.max_evaluations});
            if (CW'(k) == dim_m1) begin
              k <= '0;
              row <= '0;
              state <= S_SRT_KRD;
            end else begin
              k <= k + 1'b1;
              state <= S_FINISH;
            end
          end
        end
        S_SRT_KRD: state <= S_SRT_KLD;
        S_SRT_KLD: begin
          ki <= k_rdata;
          scan <= '0;
          rank <= '0;
          state <= S_SRT_SRD;
        end
        S_SRT_SRD: state <= S_SRT_SCMP;
        S_SRT_SCMP: begin
          // Rank counts shorter rows and equal rows that come earlier.
          if (k_rdata < ki || (k_rdata == ki && scan < row)) begin
            rank <= rank + 1'b1;
          end
          if (scan == dim_m1) begin
            col <= '0;
            state <= S_CPY_RD;
          end else begin
            scan <= scan + 1'b1;
            state <= S_SRT_SRD;
          end
        end
        S_CPY_RD: state <= S_CPY_WR;
        S_CPY_WR: begin
          if (col == dim_m1) begin
            col <= '0;
            if (row == dim_m1) begin
              bank <= ~bank;
              row <= '0;
              msum <= '0;
              state <= S_MEAN_RD;
            end else begin
              row <= row + 1'b1;
              state <= S_SRT_KRD;
            end
          end else begin
            col <= col + 1'b1;
            state <= S_CPY_RD;
          end
        end
        S_MEAN_RD: state <= S_MEAN_ACC;
        S_MEAN_ACC: begin
          msum <= msum + WIDE_W'(d_rdata);
          if (row == dim_m1) begin
            state <= S_MEAN_DIV;
          end else begin
            row <= row + 1'b1;
            state <= S_MEAN_RD;
          end
        end
        S_MEAN_DIV: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean <= msum[WIDE_W-1] ? 32'(-div_quotient) : 32'(div_quotient);
            state <= S_MEAN_WR;
          end
        end
        S_MEAN_WR: begin
          if (col == dim_m1) begin
            state <= S_FINISH;
          end else begin
            col <= col + 1'b1;
            row <= '0;
            msum <= '0;
            state <= S_MEAN_RD;
          end
        end
        S_FINISH: begin
          col <= '0;
          if (stop) begin
            phase <= PH_DONE;
            emit_kind <= dsps_pkg::KIND_FINAL;
            emit_sign <= SG_NONE;
          end else begin
            phase <= PH_MINUS;
            emit_kind <= dsps_pkg::KIND_POINT;
            emit_sign <= SG_MINUS;
          end
          state <= S_EMIT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result never waits while a new input transaction can be taken.
  assert property (@(posedge clk) disable iff (rst) !(result.valid && item.ready))
    else $error("result pending while input is ready");

  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (rst) dim <= CW'(MAX_DIM))
    else $error("dimension beyond MAX_DIM");

  assert property (@(posedge clk) disable iff (rst)
    (phase != PH_LOAD) |-> (CW'(k) < dim))
    else $error("direction index outside the loaded dimension");

  assert property (@(posedge clk) disable iff (rst) eval_count >= $past(eval_count))
    else $error("evaluation count went backward");

endmodule

// ===== src/direction_set_pattern_search.sv =====
// Adaptive direction-set pattern search in signed Q16.16. Load the start point with
// action 0 (last_coord on the final coordinate); the block answers with points to
// evaluate, one coordinate per result transaction, and expects one objective value
// (action 1) per point. The final load coordinate starts direction setup, then the
// start point; an objective value for the start point or the first trial starts the
// next point, and one for the second trial first runs the direction update and a
// length pass through the single read port of the directions RAM, the 32-step square
// root per direction and the bit-serial divider; the value that closes a sweep adds
// the rank sort, row copy and mean. Result stalls hold the search back. The search
// ends with one kind-1 point; after that inputs are accepted and ignored until reset.
// No clearing pass follows reset.
module direction_set_pattern_search #(
  parameter int MAX_DIM = dsps_pkg::MAX_DIM_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  dsps_item_if.sink      item,
  dsps_result_if.source  result,
  dsps_cfg_if.sink       cfg
);

  dsps_pkg::cfg_regs_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rho_initial <= dsps_pkg::RHO_INITIAL_RST;
      regs.rho_stop <= dsps_pkg::RHO_STOP_RST;
      regs.gain_success <= dsps_pkg::GAIN_SUCCESS_RST;
      regs.gain_failure <= dsps_pkg::GAIN_FAILURE_RST;
      regs.max_evaluations <= dsps_pkg::MAX_EVALUATIONS_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        dsps_pkg::REG_RHO_INITIAL:     regs.rho_initial <= cfg.data[30:0];
        dsps_pkg::REG_RHO_STOP:        regs.rho_stop <= cfg.data[30:0];
        dsps_pkg::REG_GAIN_SUCCESS:    regs.gain_success <= cfg.data[18:0];
        dsps_pkg::REG_GAIN_FAILURE:    regs.gain_failure <= cfg.data[18:0];
        dsps_pkg::REG_MAX_EVALUATIONS: regs.max_evaluations <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  dsps_core #(.MAX_DIM(MAX_DIM)) u_core (
    .clk(clk),
    .rst(rst),
    .regs(regs),
    .item(item),
    .result(result)
  );

endmodule

// ===== tb/direction_set_pattern_search_test.sv =====
// Self-checking testbench for direction_set_pattern_search: loads a start point, plays the
// objective evaluator and checks every emitted coordinate against a built-in predictor.
// Depends on dsps_pkg, the three channel interfaces and the search block.
module direction_set_pattern_search_test;

  localparam int DIM_CAP = 16;
  localparam int SETTLE = 4000;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef enum logic [2:0] {ST_LOAD, ST_START, ST_MINUS, ST_PLUS, ST_DONE} search_state_t;

  typedef struct {
    logic kind;
    logic [3:0] idx;
    logic signed [31:0] cv;
    logic last;
    logic signed [31:0] best;
  } coord_t;

  logic clk;
  logic rst;
  dsps_item_if item_ch();
  dsps_result_if res_ch();
  dsps_cfg_if cfg_ch();

  direction_set_pattern_search u_top (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
  );

  // Predictor state.
  int unsigned rho_init_r, rho_stop_r, gain_ok_r, gain_bad_r, eval_limit_r;
  int guess_q[DIM_CAP];
  int dirs[DIM_CAP][DIM_CAP];
  int best_obj, minus_obj;
  int unsigned eval_cnt, dir_idx, dim;
  search_state_t state;
  coord_t pending_coords[$];

  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  int hold_off = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int sat_q(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int scale_step(int d, int unsigned g);
    longint p;
    longint unsigned mag, r;
    p = longint'(d) * longint'(g);
    mag = (p < 0) ? longint'(-p) : p;
    r = (mag + 32768) >> 16;
    if (r > 64'h80000000) r = 64'h80000000;
    return (p < 0) ? sat_q(-longint'(r)) : sat_q(longint'(r));
  endfunction

  function automatic longint unsigned row_energy(int r);
    longint unsigned s, q;
    s = 0;
    for (int i = 0; i < dim; i++) begin
      q = longint'(dirs[r][i]) * longint'(dirs[r][i]);
      s = (s > 64'hFFFFFFFFFFFFFFFF - q) ? 64'hFFFFFFFFFFFFFFFF : s + q;
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000000000000000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void queue_point(logic kind, int sign);
    coord_t c;
    longint v;
    for (int i = 0; i < dim; i++) begin
      v = guess_q[i];
      if (sign < 0) v -= dirs[dir_idx][i];
      if (sign > 0) v += dirs[dir_idx][i];
      c.kind = kind;
      c.idx = i[3:0];
      c.cv = sat_q(v);
      c.last = (i + 1 == dim);
      c.best = best_obj;
      pending_coords = {pending_coords, c};
    end
  endfunction

  // Stable insertion sort by squared length, then the longest row becomes the mean row.
  function automatic void reshape_directions();
    longint unsigned key[DIM_CAP];
    longint unsigned kk;
    int row[DIM_CAP];
    int j;
    longint s;
    for (int i = 0; i < dim; i++) key[i] = row_energy(i);
    for (int i = 1; i < dim; i++) begin
      kk = key[i];
      row = dirs[i];
      j = i;
      while (j > 0 && key[j-1] > kk) begin
        key[j] = key[j-1];
        dirs[j] = dirs[j-1];
        j--;
      end
      key[j] = kk;
      dirs[j] = row;
    end
    for (int c = 0; c < dim; c++) begin
      s = 0;
      for (int i = 0; i < dim; i++) s += dirs[i][c];
      row[c] = sat_q(s / longint'(dim));
    end
    for (int c = 0; c < dim; c++) dirs[dim-1][c] = row[c];
  endfunction

  function automatic void bump_evals();
    if (eval_cnt < 25'h1FFFFFF) eval_cnt++;
  endfunction

  function automatic void search_step(logic action, int val, logic lastc);
    int minus_pt[DIM_CAP], plus_pt[DIM_CAP];
    bit improved;
    longint unsigned total, rho;
    if (state == ST_LOAD) begin
      if (action != dsps_pkg::ACT_LOAD) return;
      if (dim < DIM_CAP) begin
        guess_q[dim] = val;
        dim++;
      end
      if (!lastc) return;
      for (int i = 0; i < dim; i++)
        for (int c = 0; c < dim; c++) dirs[i][c] = (i == c) ? int'(rho_init_r) : 0;
      dir_idx = 0;
      state = ST_START;
      queue_point(dsps_pkg::KIND_POINT, 0);
      return;
    end
    if (action != dsps_pkg::ACT_VALUE || state == ST_DONE) return;
    case (state)
      ST_START: begin
        best_obj = val;
        bump_evals();
        state = ST_MINUS;
        queue_point(dsps_pkg::KIND_POINT, -1);
      end
      ST_MINUS: begin
        minus_obj = val;
        bump_evals();
        state = ST_PLUS;
        queue_point(dsps_pkg::KIND_POINT, 1);
      end
      default: begin
        bump_evals();
        improved = 0;
        for (int i = 0; i < dim; i++) begin
          minus_pt[i] = sat_q(longint'(guess_q[i]) - dirs[dir_idx][i]);
          plus_pt[i] = sat_q(longint'(guess_q[i]) + dirs[dir_idx][i]);
        end
        if (minus_obj < best_obj) begin
          best_obj = minus_obj;
          for (int i = 0; i < dim; i++) guess_q[i] = minus_pt[i];
          improved = 1;
        end
        if (val < best_obj) begin
          best_obj = val;
          for (int i = 0; i < dim; i++) guess_q[i] = plus_pt[i];
          improved = 1;
        end
        for (int i = 0; i < dim; i++)
          dirs[dir_idx][i] = scale_step(dirs[dir_idx][i], improved ? gain_ok_r : gain_bad_r);
        total = 0;
        for (int i = 0; i < dim; i++) total += int_sqrt(row_energy(i));
        rho = total / dim;
        dir_idx++;
        if (dir_idx >= dim) begin
          reshape_directions();
          dir_idx = 0;
        end
        if (rho < rho_stop_r || eval_cnt > eval_limit_r) begin
          state = ST_DONE;
          queue_point(dsps_pkg::KIND_FINAL, 0);
        end else begin
          state = ST_MINUS;
          queue_point(dsps_pkg::KIND_POINT, -1);
        end
      end
    endcase
  endfunction

  // Result checker.
  always @(posedge clk) begin
    coord_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected result transaction: index %0d value %0d",
               res_ch.coord_index, res_ch.coord_value);
        errors++;
      end else begin
        e = pending_coords.pop_front();
        if (res_ch.kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, res_ch.kind);
          errors++;
        end
        if (res_ch.coord_index !== e.idx) begin
          $error("coord_index: expected %0d, actual %0d", e.idx, res_ch.coord_index);
          errors++;
        end
        if (res_ch.coord_value !== e.cv) begin
          $error("coord_value: expected %0d, actual %0d", e.cv, res_ch.coord_value);
          errors++;
        end
        if (res_ch.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, res_ch.last);
          errors++;
        end
        if (res_ch.best_score !== e.best) begin
          $error("best_score: expected %0d, actual %0d", e.best, res_ch.best_score);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure: changing stall modes, plus an optional long hold-off.
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    res_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_off > 0) begin
        hold_off--;
        res_ch.ready = 0;
      end else begin
        case (mode)
          0: res_ch.ready = 1;
          1: res_ch.ready = $urandom_range(0, 1);
          default: res_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_item(logic action, int val, logic lastc);
    item_ch.action = action;
    item_ch.value = val;
    item_ch.last_coord = lastc;
    item_ch.valid = 1;
    do @(posedge clk); while (!item_ch.ready);
    search_step(action, val, lastc);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_ch.valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  task automatic write_reg(logic [dsps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      dsps_pkg::REG_RHO_INITIAL: rho_init_r = data & 32'h7FFFFFFF;
      dsps_pkg::REG_RHO_STOP: rho_stop_r = data & 32'h7FFFFFFF;
      dsps_pkg::REG_GAIN_SUCCESS: gain_ok_r = data & 32'h7FFFF;
      dsps_pkg::REG_GAIN_FAILURE: gain_bad_r = data & 32'h7FFFF;
      dsps_pkg::REG_MAX_EVALUATIONS: eval_limit_r = data & 32'hFFFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic wait_idle();
    item_ch.valid = 0;
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // An objective value that often beats the current best.
  function automatic int pick_objective();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return best_obj;
      default: return sat_q(longint'(best_obj) - $urandom_range(0, 1 << 18));
    endcase
  endfunction

  task automatic test_ignored_while_loading();
    send_item(dsps_pkg::ACT_VALUE, 32'h7FFFFFFF, 1);
    send_item(dsps_pkg::ACT_VALUE, 32'h80000000, 0);
  endtask

  // Seventeen coordinates: the last one is dropped but still ends the load.
  task automatic test_load_overflow();
    int v;
    for (int i = 0; i < 17; i++) begin
      case (i)
        0: v = 32'h80000000;
        1: v = 32'h7FFFFFFF;
        2: v = 0;
        3: v = -1;
        default: v = $urandom_range(0, 1 << 22) - (1 << 21);
      endcase
      send_item(dsps_pkg::ACT_LOAD, v, i == 16);
    end
  endtask

  task automatic test_directed_trials();
    send_item(dsps_pkg::ACT_VALUE, 32'h00100000, 0);
    send_item(dsps_pkg::ACT_LOAD, 32'h12345678, 1);
    send_item(dsps_pkg::ACT_VALUE, 32'h00080000, 1);
    send_item(dsps_pkg::ACT_VALUE, 32'h00200000, 0);
    send_item(dsps_pkg::ACT_VALUE, 32'h7FFFFFFF, 0);
    send_item(dsps_pkg::ACT_VALUE, 32'h80000000, 0);
    send_item(dsps_pkg::ACT_VALUE, 32'h80000000, 0);
    send_item(dsps_pkg::ACT_VALUE, 32'h80000000, 0);
  endtask

  task automatic test_random_search();
    int unsigned g[3];
    for (int n = 0; n < 370; n++) begin
      if (n % 90 == 89) begin
        wait_idle();
        g[0] = 0;
        g[1] = 262144;
        g[2] = $urandom_range(16384, 200000);
        write_reg(dsps_pkg::REG_GAIN_SUCCESS, g[$urandom_range(1, 2)]);
        write_reg(dsps_pkg::REG_GAIN_FAILURE, g[$urandom_range(0, 2)]);
        write_reg(dsps_pkg::REG_MAX_EVALUATIONS, 24'hFFFFFF);
        write_reg(dsps_pkg::REG_RHO_STOP, 0);
      end
      if (n == 200) hold_off = 3000;
      if ($urandom_range(0, 9) == 0)
        send_item(dsps_pkg::ACT_LOAD, $urandom, $urandom_range(0, 1));
      else
        send_item(dsps_pkg::ACT_VALUE, pick_objective(), $urandom_range(0, 1));
    end
  endtask

  // Force the stop condition, then check that later inputs are ignored.
  task automatic test_stop();
    wait_idle();
    write_reg(dsps_pkg::REG_MAX_EVALUATIONS, 0);
    write_reg(dsps_pkg::REG_RHO_STOP, 31'h7FFFFFFF);
    for (int i = 0; i < 3 && state != ST_DONE; i++)
      send_item(dsps_pkg::ACT_VALUE, pick_objective(), 0);
    send_item(dsps_pkg::ACT_VALUE, 0, 0);
    send_item(dsps_pkg::ACT_LOAD, 5, 1);
  endtask

  initial begin
    item_ch.valid = 0;
    item_ch.action = dsps_pkg::ACT_LOAD;
    item_ch.value = 0;
    item_ch.last_coord = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = dsps_pkg::REG_RHO_INITIAL;
    cfg_ch.data = 0;
    rho_init_r = dsps_pkg::RHO_INITIAL_RST;
    rho_stop_r = dsps_pkg::RHO_STOP_RST;
    gain_ok_r = dsps_pkg::GAIN_SUCCESS_RST;
    gain_bad_r = dsps_pkg::GAIN_FAILURE_RST;
    eval_limit_r = dsps_pkg::MAX_EVALUATIONS_RST;
    best_obj = 0;
    minus_obj = 0;
    eval_cnt = 0;
    dir_idx = 0;
    dim = 0;
    state = ST_LOAD;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(dsps_pkg::REG_RHO_INITIAL, 31'h7FFFFFFF);
    write_reg(dsps_pkg::REG_RHO_INITIAL, $urandom_range(1 << 12, 1 << 20));
    write_reg(dsps_pkg::REG_RHO_STOP, 0);
    write_reg(dsps_pkg::REG_GAIN_SUCCESS, 262144);
    write_reg(dsps_pkg::REG_GAIN_FAILURE, $urandom_range(20000, 60000));
    write_reg(dsps_pkg::REG_MAX_EVALUATIONS, 24'hFFFFFF);

    test_ignored_while_loading();
    test_load_overflow();
    test_directed_trials();
    test_random_search();
    test_stop();

    item_ch.valid = 0;
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && pending_coords.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
